FILE: rtl/lsms_pkg.sv
package lsms_pkg;

  localparam int LIST_BITS = 16;
  localparam int IDX_W = 4;
  localparam int ADDR_W = 32;
  localparam int OFFSET_W = 7;
  localparam logic [IDX_W-1:0] PC_INDEX = 4'd15;
  localparam logic [ADDR_W-1:0] WORD_BYTES = 32'd4;
  localparam logic [1:0] ALIGN_MASK = 2'h3;

  typedef enum logic [1:0] {
    ST_XFER  = 2'd0,
    ST_ALIGN = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic [LIST_BITS-1:0] register_list;
    logic [ADDR_W-1:0]    base_addr;
    logic [IDX_W-1:0]     base_register;
    logic                 count_up;
    logic                 before_req;
    logic                 wb_req;
    logic                 is_load;
    logic                 user_mode;
  } cmd_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] transfer_address;
    logic [IDX_W-1:0]  register_index;
    logic              load_flag;
    logic              user_bank;
    logic              restore_psr;
    logic              writeback_valid;
    logic [IDX_W-1:0]  writeback_register;
    logic [ADDR_W-1:0] writeback_address;
    status_t           status;
    logic              last;
  } xfer_item_t;

  typedef struct packed {
    logic capture;
    logic calc;
    logic step;
  } ctl_cmd_t;

  typedef struct packed {
    logic slot_free;
    logic beat_last;
  } dp_stat_t;

endpackage

FILE: rtl/lsms_cmd_if.sv
interface lsms_cmd_if;
  logic                  valid;
  logic                  ready;
  lsms_pkg::cmd_item_t   data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/lsms_xfer_if.sv
interface lsms_xfer_if;
  logic                  valid;
  logic                  ready;
  lsms_pkg::xfer_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/load_store_multiple_sequencer.sv
// Sequencing: an accepted instruction passes the calc state, then the emit state steps
// out one registered beat per listed register (one beat for a fault or an empty list);
// the emit sequencer moves one transfer a cycle while the output register is free or taken.
// A new instruction is taken while the final beat still waits in the output register.
// Reset: synchronous, active high; clears the controller and the output valid.
module load_store_multiple_sequencer #(
  parameter int REGISTER_COUNT = 16
) (
  input  logic               clk,
  input  logic               rst,
  lsms_cmd_if.sink           cmd,
  lsms_xfer_if.source        xfer
);
  import lsms_pkg::*;

  ctl_cmd_t ctl;
  dp_stat_t stat;

  lsms_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  lsms_dp #(
    .REGISTER_COUNT (REGISTER_COUNT)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd_data   (cmd.data),
    .ctl        (ctl),
    .stat       (stat),
    .xfer_valid (xfer.valid),
    .xfer_ready (xfer.ready),
    .xfer_data  (xfer.data)
  );

`ifndef NO_ASSERTIONS
  a_fault_is_last: assert property (@(posedge clk) disable iff (rst)
    xfer.valid && (xfer.data.status != ST_XFER) |-> xfer.data.last &&
      !xfer.data.writeback_valid)
    else $error("fault or empty beat not final");
  a_wb_on_last: assert property (@(posedge clk) disable iff (rst)
    xfer.valid && xfer.data.writeback_valid |-> xfer.data.last && !xfer.data.user_bank)
    else $error("write-back on wrong beat");
  a_psr_on_pc_load: assert property (@(posedge clk) disable iff (rst)
    xfer.valid && xfer.data.restore_psr |-> xfer.data.load_flag &&
      (xfer.data.register_index == PC_INDEX))
    else $error("PSR restore without r15 load");
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    cmd.valid && cmd.ready |=> !cmd.ready)
    else $error("second instruction accepted during sequencing");
`endif
endmodule

FILE: rtl/lsms_ctrl.sv
module lsms_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  lsms_pkg::dp_stat_t stat,
  output lsms_pkg::ctl_cmd_t ctl
);
  import lsms_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CALC = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next  = state;
    cmd_ready   = 1'b0;
    ctl         = '0;
    unique case (state)
      S_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          ctl.capture = 1'b1;
          state_next  = S_CALC;
        end
      end
      S_CALC: begin
        ctl.calc   = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (stat.slot_free) begin
          ctl.step = 1'b1;
          if (stat.beat_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_calc_follows_capture: assert property (@(posedge clk) disable iff (rst)
    ctl.capture |=> ctl.calc)
    else $error("calc cycle missing after capture");
  a_no_step_outside_emit: assert property (@(posedge clk) disable iff (rst)
    ctl.step |-> !cmd_ready && !ctl.calc)
    else $error("step issued outside emit");
  a_last_returns_idle: assert property (@(posedge clk) disable iff (rst)
    ctl.step && stat.beat_last |=> cmd_ready)
    else $error("not idle after last beat");
`endif
endmodule

FILE: rtl/lsms_dp.sv
module lsms_dp #(
  parameter int REGISTER_COUNT = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  lsms_pkg::cmd_item_t  cmd_data,
  input  lsms_pkg::ctl_cmd_t   ctl,
  output lsms_pkg::dp_stat_t   stat,
  output logic                 xfer_valid,
  input  logic                 xfer_ready,
  output lsms_pkg::xfer_item_t xfer_data
);
  import lsms_pkg::*;

  localparam int CNT_W = OFFSET_W - 2;
  localparam logic [LIST_BITS-1:0] USABLE_MASK = (REGISTER_COUNT >= LIST_BITS) ?
      {LIST_BITS{1'b1}} : LIST_BITS'((32'd1 << REGISTER_COUNT) - 32'd1);

  logic [LIST_BITS-1:0] mask;
  logic [ADDR_W-1:0]    base;
  logic [IDX_W-1:0]     rn;
  logic                 up;
  logic                 pre_idx;
  logic                 wb_ok;
  logic                 ld;
  logic                 usr;
  logic [OFFSET_W-1:0]  offset;
  status_t              kind;
  logic [ADDR_W-1:0]    next_address;
  logic [ADDR_W-1:0]    held_writeback;

  logic [LIST_BITS-1:0] list_in;
  logic [ADDR_W-1:0]    off_ext;
  logic [ADDR_W-1:0]    adj;
  logic [ADDR_W-1:0]    start;
  logic [ADDR_W-1:0]    wb_addr;
  logic [IDX_W-1:0]     idx;
  logic [LIST_BITS-1:0] mask_next;
  logic                 beat_last;
  xfer_item_t           beat;

  assign list_in = cmd_data.register_list & USABLE_MASK;

  // start and write-back address from the base and the list offset
  assign off_ext = {{(ADDR_W-OFFSET_W){1'b0}}, offset};
  assign adj     = pre_idx ? off_ext : off_ext - WORD_BYTES;
  assign start   = up ? (pre_idx ? base + WORD_BYTES : base) : base - adj;
  assign wb_addr = up ? base + off_ext : base - off_ext;

  always_comb begin
    idx = '0;
    for (int i = LIST_BITS - 1; i >= 0; i--) begin
      if (mask[i]) begin
        idx = IDX_W'(i);
      end
    end
  end

  assign mask_next = mask & ~(LIST_BITS'(1) << idx);
  assign beat_last = (kind != ST_XFER) || (mask_next == '0);

  always_comb begin
    beat                  = '0;
    beat.transfer_address = next_address;
    beat.load_flag        = ld;
    beat.user_bank        = usr;
    beat.status           = kind;
    beat.last             = beat_last;
    if (kind == ST_XFER) begin
      beat.register_index = idx;
      beat.restore_psr    = usr & ld & (idx == PC_INDEX);
      if (wb_ok && beat_last) begin
        beat.writeback_valid    = 1'b1;
        beat.writeback_register = rn;
        beat.writeback_address  = held_writeback;
      end
    end
  end

  assign stat.slot_free = !xfer_valid || xfer_ready;
  assign stat.beat_last = beat_last;

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      mask    <= list_in;
      base    <= cmd_data.base_addr;
      rn      <= cmd_data.base_register;
      up      <= cmd_data.count_up;
      pre_idx <= cmd_data.before_req;
      wb_ok   <= cmd_data.wb_req & ~cmd_data.user_mode;
      ld      <= cmd_data.is_load;
      usr     <= cmd_data.user_mode;
      offset  <= {CNT_W'($countones(list_in)), 2'b00};
      // offsets are multiples of four, so alignment follows the base alone
      if ((cmd_data.base_addr[1:0] & ALIGN_MASK) != 2'b00) begin
        kind <= ST_ALIGN;
      end else if (list_in == '0) begin
        kind <= ST_EMPTY;
      end else begin
        kind <= ST_XFER;
      end
    end
    if (ctl.calc) begin
      next_address   <= start;
      held_writeback <= wb_addr;
    end
    if (ctl.step) begin
      mask         <= mask_next;
      next_address <= next_address + WORD_BYTES;
      xfer_data    <= beat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      xfer_valid <= 1'b0;
    end else if (ctl.step) begin
      xfer_valid <= 1'b1;
    end else if (xfer_ready) begin
      xfer_valid <= 1'b0;
    end
  end
endmodule
